@@ design/lfdr_pkg.sv @@
`default_nettype none
package lfdr_pkg;

   localparam int COMP_W = 16;
   localparam int SUM_W = 32;
   localparam int FRAC_W = 28;
   localparam int DIR_SHIFT = 14;
   localparam int ROOT_W = 30;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;
   localparam int MAG_W = 16;
   localparam int QUO_W = 15;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic signed [COMP_W-1:0] dir_x;
      logic signed [COMP_W-1:0] dir_y;
      logic signed [COMP_W-1:0] dir_z;
      logic signed [COMP_W-1:0] normal_x;
      logic signed [COMP_W-1:0] normal_y;
      logic signed [COMP_W-1:0] normal_z;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic signed [COMP_W-1:0] out_z;
      logic                     degenerate;
   } rsp_type;

   // Classified beat as it sits in the queue.
   typedef struct packed {
      req_type          req;
      logic             use_y;
      logic             degen;
      logic [SUM_W-1:0] sum;
   } item_type;

   typedef struct packed {
      logic    valid;
      req_type req;
      logic    use_y;
      logic    degen;
   } side_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qbeat_type;

endpackage
`default_nettype wire

@@ design/local_frame_direction_rotate_core.sv @@
// Channel   Ports                       Handshake
// request   start, busy, req_data       beat taken when start is high and busy is low
// response  rsp_valid, rsp_data         beat shown for one cycle, always taken
//
// One beat can be taken every cycle while busy is low.
// The depth is set by the bit-per-stage square root (30 stages) and the
// bit-per-stage rounding divider (15 stages) of the back end.
// Synchronous reset empties the queue and clears all valid flags.
// The response side cannot stall, so busy rises only if the queue fills.
`default_nettype none
module local_frame_direction_rotate_core #(
   parameter int QUEUE_DEPTH = lfdr_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire lfdr_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output lfdr_pkg::rsp_type       rsp_data
);

   lfdr_pkg::qbeat_type push_beat;
   lfdr_pkg::qbeat_type pop_beat;
   logic                queue_full;

   lfdr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .push_beat  (push_beat),
      .queue_full (queue_full)
   );

   lfdr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_beat (push_beat),
      .full      (queue_full),
      .pop_beat  (pop_beat)
   );

   lfdr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_beat  (pop_beat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ design/lfdr_front.sv @@
`default_nettype none
module lfdr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire lfdr_pkg::req_type  req_data,
   output lfdr_pkg::qbeat_type     push_beat,
   input  wire logic               queue_full
);

   logic                        valid_ff;
   lfdr_pkg::item_type          item_ff;
   lfdr_pkg::item_type          item_in;
   logic                        stall;
   logic                        accept;
   logic signed [31:0]          nx2;
   logic signed [31:0]          ny2;
   logic signed [31:0]          nz2;
   logic [lfdr_pkg::SUM_W-1:0]  sum_x;
   logic [lfdr_pkg::SUM_W-1:0]  sum_y;

   assign stall  = valid_ff & queue_full;
   assign busy   = stall;
   assign accept = start & ~stall;

   always_comb begin
      nx2 = req_data.normal_x * req_data.normal_x;
      ny2 = req_data.normal_y * req_data.normal_y;
      nz2 = req_data.normal_z * req_data.normal_z;
      sum_x = $unsigned(nx2) + $unsigned(nz2);
      sum_y = $unsigned(ny2) + $unsigned(nz2);
      item_in.req = req_data;
      // A tie of the squares takes the y/z based tangent.
      item_in.use_y = !(nx2 > ny2);
      item_in.sum = item_in.use_y ? sum_y : sum_x;
      item_in.degen = (item_in.sum == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!stall) begin
         valid_ff <= accept;
      end
      if (!stall && accept) begin
         item_ff <= item_in;
      end
   end

   assign push_beat.valid = valid_ff & ~queue_full;
   assign push_beat.item  = item_ff;

endmodule
`default_nettype wire

@@ design/lfdr_queue.sv @@
`default_nettype none
module lfdr_queue #(
   parameter int DEPTH = lfdr_pkg::QUEUE_DEPTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lfdr_pkg::qbeat_type  push_beat,
   output logic                      full,
   output lfdr_pkg::qbeat_type       pop_beat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfdr_pkg::item_type  mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                pop;

   // The back end never stalls, so any stored beat leaves at once.
   assign pop  = (count_ff != '0);
   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_beat.valid = pop;
   assign pop_beat.item  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_beat.valid) begin
         mem_ff[wr_ptr_ff] <= push_beat.item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push_beat.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_beat.valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push_beat.valid && pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

@@ design/lfdr_sqrt.sv @@
`default_nettype none
module lfdr_sqrt (
   input  wire logic                          clock,
   input  wire logic [lfdr_pkg::RAD_W-1:0]    radicand,
   output logic [lfdr_pkg::ROOT_W-1:0]        root
);

   localparam int RW = lfdr_pkg::ROOT_W;
   localparam int EW = lfdr_pkg::REM_W;
   localparam int VW = lfdr_pkg::RAD_W;

   logic [VW-1:0] rad_in  [RW];
   logic [EW-1:0] rem_in  [RW];
   logic [RW-1:0] root_in [RW];
   logic [VW-1:0] rad_ff  [RW];
   logic [EW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];

   // One root bit per stage, most significant bit pair first.
   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int BIT_LO = 2 * (RW - 1 - k);
      logic [EW-1:0] rem_sh;
      logic [EW-1:0] trial;

      if (k == 0) begin : g_head
         assign rad_in[k]  = radicand;
         assign rem_in[k]  = '0;
         assign root_in[k] = '0;
      end else begin : g_link
         assign rad_in[k]  = rad_ff[k-1];
         assign rem_in[k]  = rem_ff[k-1];
         assign root_in[k] = root_ff[k-1];
      end

      assign rem_sh = {rem_in[k][EW-3:0], rad_in[k][BIT_LO+1:BIT_LO]};
      assign trial  = {1'b0, root_in[k], 2'b01};

      always_ff @(posedge clock) begin
         rad_ff[k] <= rad_in[k];
         if (rem_sh >= trial) begin
            rem_ff[k]  <= rem_sh - trial;
            root_ff[k] <= {root_in[k][RW-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= rem_sh;
            root_ff[k] <= {root_in[k][RW-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule
`default_nettype wire

@@ design/lfdr_div.sv @@
`default_nettype none
module lfdr_div (
   input  wire logic                          clock,
   input  wire logic [lfdr_pkg::MAG_W-1:0]    mag,
   input  wire logic [lfdr_pkg::ROOT_W-1:0]   divisor,
   output logic [lfdr_pkg::QUO_W-1:0]         quotient
);

   localparam int LW = lfdr_pkg::ROOT_W;
   localparam int QW = lfdr_pkg::QUO_W;
   localparam int DW = lfdr_pkg::MAG_W + lfdr_pkg::FRAC_W + 1;

   logic [DW-1:0] dividend;
   logic [LW-1:0] rem_in  [QW];
   logic [QW-1:0] low_in  [QW];
   logic [LW-1:0] dsr_in  [QW];
   logic [QW-1:0] quo_in  [QW];
   logic [LW-1:0] rem_ff  [QW];
   logic [QW-1:0] low_ff  [QW];
   logic [LW-1:0] dsr_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];

   // Adding half the divisor first gives round to nearest, ties away from zero.
   // The quotient is below 2^QW, so the upper dividend bits start below the divisor.
   assign dividend = {1'b0, mag, {lfdr_pkg::FRAC_W{1'b0}}} + DW'(divisor >> 1);

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [LW:0] rem_sh;

      if (k == 0) begin : g_head
         assign rem_in[k] = dividend[DW-1:QW];
         assign low_in[k] = dividend[QW-1:0];
         assign dsr_in[k] = divisor;
         assign quo_in[k] = '0;
      end else begin : g_link
         assign rem_in[k] = rem_ff[k-1];
         assign low_in[k] = low_ff[k-1];
         assign dsr_in[k] = dsr_ff[k-1];
         assign quo_in[k] = quo_ff[k-1];
      end

      assign rem_sh = {rem_in[k], low_in[k][QW-1-k]};

      always_ff @(posedge clock) begin
         low_ff[k] <= low_in[k];
         dsr_ff[k] <= dsr_in[k];
         if (rem_sh >= {1'b0, dsr_in[k]}) begin
            rem_ff[k] <= LW'(rem_sh - {1'b0, dsr_in[k]});
            quo_ff[k] <= {quo_in[k][QW-2:0], 1'b1};
         end else begin
            rem_ff[k] <= rem_sh[LW-1:0];
            quo_ff[k] <= {quo_in[k][QW-2:0], 1'b0};
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule
`default_nettype wire

@@ design/lfdr_back.sv @@
`default_nettype none
module lfdr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lfdr_pkg::qbeat_type  pop_beat,
   output logic                      rsp_valid,
   output lfdr_pkg::rsp_type         rsp_data
);

   localparam int CW  = lfdr_pkg::COMP_W;
   localparam int DLY = lfdr_pkg::ROOT_W + lfdr_pkg::QUO_W;
   localparam int PW  = 2 * CW;
   localparam int LFW = PW + 1;
   localparam int YW  = LFW + CW;
   localparam int AW  = YW + 3;
   localparam int RDW = AW - lfdr_pkg::FRAC_W;

   function automatic logic [lfdr_pkg::MAG_W-1:0] mag_of(input logic signed [CW-1:0] v);
      logic [lfdr_pkg::MAG_W-1:0] r;
      r = v[CW-1] ? lfdr_pkg::MAG_W'(-v) : lfdr_pkg::MAG_W'(v);
      return r;
   endfunction

   lfdr_pkg::side_type           side_ff [DLY];
   lfdr_pkg::side_type           side_in;
   lfdr_pkg::side_type           mid;
   lfdr_pkg::side_type           tail;
   logic [lfdr_pkg::RAD_W-1:0]   radicand;
   logic [lfdr_pkg::ROOT_W-1:0]  root;
   logic [lfdr_pkg::MAG_W-1:0]   mag_a;
   logic [lfdr_pkg::MAG_W-1:0]   mag_b;
   logic [lfdr_pkg::QUO_W-1:0]   quo_a;
   logic [lfdr_pkg::QUO_W-1:0]   quo_b;
   logic signed [CW-1:0]         qa_s;
   logic signed [CW-1:0]         qb_s;

   assign side_in.valid = pop_beat.valid;
   assign side_in.req   = pop_beat.item.req;
   assign side_in.use_y = pop_beat.item.use_y;
   assign side_in.degen = pop_beat.item.degen;
   assign radicand = {pop_beat.item.sum, {lfdr_pkg::FRAC_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY; k++) begin
            side_ff[k] <= '0;
         end
      end else begin
         side_ff[0] <= side_in;
         for (int k = 1; k < DLY; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   lfdr_sqrt u_sqrt (
      .clock    (clock),
      .radicand (radicand),
      .root     (root)
   );

   assign mid   = side_ff[lfdr_pkg::ROOT_W-1];
   assign mag_a = mag_of(mid.req.normal_z);
   assign mag_b = mid.use_y ? mag_of(mid.req.normal_y) : mag_of(mid.req.normal_x);

   lfdr_div u_div_a (
      .clock    (clock),
      .mag      (mag_a),
      .divisor  (root),
      .quotient (quo_a)
   );

   lfdr_div u_div_b (
      .clock    (clock),
      .mag      (mag_b),
      .divisor  (root),
      .quotient (quo_b)
   );

   assign tail = side_ff[DLY-1];
   assign qa_s = $signed({1'b0, quo_a});
   assign qb_s = $signed({1'b0, quo_b});

   // Tangent components with the signs of their numerators restored.
   logic                 u_valid_ff;
   logic                 u_degen_ff;
   lfdr_pkg::req_type    u_req_ff;
   logic signed [CW-1:0] ux_ff, uy_ff, uz_ff;

   always_ff @(posedge clock) begin
      u_valid_ff <= reset ? 1'b0 : tail.valid;
      u_degen_ff <= tail.degen;
      u_req_ff   <= tail.req;
      if (tail.use_y) begin
         ux_ff <= '0;
         uy_ff <= tail.req.normal_z[CW-1] ? -qa_s : qa_s;
         uz_ff <= (tail.req.normal_y > 0) ? -qb_s : qb_s;
      end else begin
         ux_ff <= (tail.req.normal_z > 0) ? -qa_s : qa_s;
         uy_ff <= '0;
         uz_ff <= tail.req.normal_x[CW-1] ? -qb_s : qb_s;
      end
   end

   logic                 p_valid_ff;
   logic                 p_degen_ff;
   logic signed [CW-1:0] p_dy_ff;
   logic signed [PW-1:0] p_nyuz_ff, p_nzuy_ff, p_nzux_ff, p_nxuz_ff, p_nxuy_ff, p_nyux_ff;
   logic signed [PW-1:0] p_dux_ff, p_duy_ff, p_duz_ff, p_dnx_ff, p_dny_ff, p_dnz_ff;

   always_ff @(posedge clock) begin
      p_valid_ff <= reset ? 1'b0 : u_valid_ff;
      p_degen_ff <= u_degen_ff;
      p_dy_ff    <= u_req_ff.dir_y;
      p_nyuz_ff  <= u_req_ff.normal_y * uz_ff;
      p_nzuy_ff  <= u_req_ff.normal_z * uy_ff;
      p_nzux_ff  <= u_req_ff.normal_z * ux_ff;
      p_nxuz_ff  <= u_req_ff.normal_x * uz_ff;
      p_nxuy_ff  <= u_req_ff.normal_x * uy_ff;
      p_nyux_ff  <= u_req_ff.normal_y * ux_ff;
      p_dux_ff   <= u_req_ff.dir_x * ux_ff;
      p_duy_ff   <= u_req_ff.dir_x * uy_ff;
      p_duz_ff   <= u_req_ff.dir_x * uz_ff;
      p_dnx_ff   <= u_req_ff.dir_z * u_req_ff.normal_x;
      p_dny_ff   <= u_req_ff.dir_z * u_req_ff.normal_y;
      p_dnz_ff   <= u_req_ff.dir_z * u_req_ff.normal_z;
   end

   logic                  l_valid_ff;
   logic                  l_degen_ff;
   logic signed [CW-1:0]  l_dy_ff;
   logic signed [LFW-1:0] lx_ff, ly_ff, lz_ff;
   logic signed [PW-1:0]  l_dux_ff, l_duy_ff, l_duz_ff, l_dnx_ff, l_dny_ff, l_dnz_ff;

   always_ff @(posedge clock) begin
      l_valid_ff <= reset ? 1'b0 : p_valid_ff;
      l_degen_ff <= p_degen_ff;
      l_dy_ff    <= p_dy_ff;
      lx_ff <= LFW'(p_nyuz_ff) - LFW'(p_nzuy_ff);
      ly_ff <= LFW'(p_nzux_ff) - LFW'(p_nxuz_ff);
      lz_ff <= LFW'(p_nxuy_ff) - LFW'(p_nyux_ff);
      l_dux_ff <= p_dux_ff;
      l_duy_ff <= p_duy_ff;
      l_duz_ff <= p_duz_ff;
      l_dnx_ff <= p_dnx_ff;
      l_dny_ff <= p_dny_ff;
      l_dnz_ff <= p_dnz_ff;
   end

   logic                 y_valid_ff;
   logic                 y_degen_ff;
   logic signed [YW-1:0] ylx_ff, yly_ff, ylz_ff;
   logic signed [PW-1:0] y_dux_ff, y_duy_ff, y_duz_ff, y_dnx_ff, y_dny_ff, y_dnz_ff;

   always_ff @(posedge clock) begin
      y_valid_ff <= reset ? 1'b0 : l_valid_ff;
      y_degen_ff <= l_degen_ff;
      ylx_ff <= l_dy_ff * lx_ff;
      yly_ff <= l_dy_ff * ly_ff;
      ylz_ff <= l_dy_ff * lz_ff;
      y_dux_ff <= l_dux_ff;
      y_duy_ff <= l_duy_ff;
      y_duz_ff <= l_duz_ff;
      y_dnx_ff <= l_dnx_ff;
      y_dny_ff <= l_dny_ff;
      y_dnz_ff <= l_dnz_ff;
   end

   // Exact Q.42 sums.
   logic                 s_valid_ff;
   logic                 s_degen_ff;
   logic signed [AW-1:0] sx_ff, sy_ff, sz_ff;

   always_ff @(posedge clock) begin
      s_valid_ff <= reset ? 1'b0 : y_valid_ff;
      s_degen_ff <= y_degen_ff;
      sx_ff <= (AW'(y_dux_ff) <<< lfdr_pkg::DIR_SHIFT) + AW'(ylx_ff)
         + (AW'(y_dnx_ff) <<< lfdr_pkg::DIR_SHIFT);
      sy_ff <= (AW'(y_duy_ff) <<< lfdr_pkg::DIR_SHIFT) + AW'(yly_ff)
         + (AW'(y_dny_ff) <<< lfdr_pkg::DIR_SHIFT);
      sz_ff <= (AW'(y_duz_ff) <<< lfdr_pkg::DIR_SHIFT) + AW'(ylz_ff)
         + (AW'(y_dnz_ff) <<< lfdr_pkg::DIR_SHIFT);
   end

   function automatic logic signed [CW-1:0] round_sat(input logic signed [AW-1:0] v);
      logic signed [AW-1:0]  biased;
      logic signed [RDW-1:0] r;
      logic signed [CW-1:0]  o;
      biased = v + (AW'(1) <<< (lfdr_pkg::FRAC_W - 1));
      r = RDW'(biased >>> lfdr_pkg::FRAC_W);
      if (r > RDW'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
         o = {1'b0, {(CW-1){1'b1}}};
      end else if (r < -(RDW'(1) <<< (CW - 1))) begin
         o = {1'b1, {(CW-1){1'b0}}};
      end else begin
         o = r[CW-1:0];
      end
      return o;
   endfunction

   logic               o_valid_ff;
   lfdr_pkg::rsp_type  o_data_ff;

   always_ff @(posedge clock) begin
      o_valid_ff <= reset ? 1'b0 : s_valid_ff;
      if (s_degen_ff) begin
         o_data_ff.out_x <= '0;
         o_data_ff.out_y <= '0;
         o_data_ff.out_z <= '0;
         o_data_ff.degenerate <= 1'b1;
      end else begin
         o_data_ff.out_x <= round_sat(sx_ff);
         o_data_ff.out_y <= round_sat(sy_ff);
         o_data_ff.out_z <= round_sat(sz_ff);
         o_data_ff.degenerate <= 1'b0;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

endmodule
`default_nettype wire

@@ tb/local_frame_direction_rotate_core_test.sv @@
`default_nettype none
module local_frame_direction_rotate_core_test;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   lfdr_pkg::req_type req_data;
   logic              rsp_valid;
   lfdr_pkg::rsp_type rsp_data;

   lfdr_pkg::rsp_type rotated_q[$];
   int                mismatches;
   bit                idle_enable;

   local_frame_direction_rotate_core uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint round_div(longint num, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [15:0] round_sat(longint v);
      longint r;
      r = (v + (64'sd1 <<< 27)) >>> 28;
      if (r < -32768) r = -32768;
      if (r > 32767) r = 32767;
      return r[15:0];
   endfunction

   function automatic lfdr_pkg::rsp_type rotate_direction(lfdr_pkg::req_type r);
      lfdr_pkg::rsp_type o;
      longint dx, dy, dz, nx, ny, nz, a1, a2, a3;
      longint ux, uy, uz, lx, ly, lz, ox, oy, oz;
      longint unsigned sum, len;
      dx = r.dir_x;
      dy = r.dir_y;
      dz = r.dir_z;
      nx = r.normal_x;
      ny = r.normal_y;
      nz = r.normal_z;
      // A tie between the squares picks the y,z based tangent.
      if (nx * nx > ny * ny) begin
         sum = nx * nx + nz * nz;
         a1 = -nz; a2 = 0; a3 = nx;
      end else begin
         sum = ny * ny + nz * nz;
         a1 = 0; a2 = nz; a3 = -ny;
      end
      o = '0;
      if (sum == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      len = int_sqrt(sum << 28);
      ux = round_div(a1 <<< 28, len);
      uy = round_div(a2 <<< 28, len);
      uz = round_div(a3 <<< 28, len);
      lx = ny * uz - nz * uy;
      ly = nz * ux - nx * uz;
      lz = nx * uy - ny * ux;
      ox = ((dx * ux) <<< 14) + dy * lx + ((dz * nx) <<< 14);
      oy = ((dx * uy) <<< 14) + dy * ly + ((dz * ny) <<< 14);
      oz = ((dx * uz) <<< 14) + dy * lz + ((dz * nz) <<< 14);
      o.out_x = round_sat(ox);
      o.out_y = round_sat(oy);
      o.out_z = round_sat(oz);
      return o;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      lfdr_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (rotated_q.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            want = rotated_q.pop_front();
            if (rsp_data.out_x !== want.out_x)
               report_mismatch("out_x", rsp_data.out_x, want.out_x);
            if (rsp_data.out_y !== want.out_y)
               report_mismatch("out_y", rsp_data.out_y, want.out_y);
            if (rsp_data.out_z !== want.out_z)
               report_mismatch("out_z", rsp_data.out_z, want.out_z);
            if (rsp_data.degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_data.degenerate, want.degenerate);
         end
      end
   end

   // Start stays high across back-to-back beats; it drops only for a random gap or in wait_drained.
   task automatic send_beat(lfdr_pkg::req_type r);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      rotated_q.push_back(rotate_direction(r));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'h4000;
         4: return 16'hc000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic lfdr_pkg::req_type random_unit_item();
      lfdr_pkg::req_type r;
      real a, b;
      a = ($urandom % 62832) / 10000.0;
      b = ($urandom % 31416) / 10000.0;
      r.dir_x = 16'($urandom_range(0, 32767) - 16384);
      r.dir_y = 16'($urandom_range(0, 32767) - 16384);
      r.dir_z = 16'($urandom_range(0, 32767) - 16384);
      r.normal_x = 16'($rtoi(16384.0 * $sin(b) * $cos(a)));
      r.normal_y = 16'($rtoi(16384.0 * $sin(b) * $sin(a)));
      r.normal_z = 16'($rtoi(16384.0 * $cos(b)));
      return r;
   endfunction

   task automatic test_directed();
      lfdr_pkg::req_type r;
      // Axis normals, squares tie, zero normal, and extreme components.
      r = '{16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
      send_beat(r);
      r = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0};
      send_beat(r);
      r = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384};
      send_beat(r);
      r = '{16'sd1000, 16'sd2000, 16'sd3000, 16'sd11585, -16'sd11585, 16'sd0};
      send_beat(r);
      r = '{16'sd1000, 16'sd2000, 16'sd3000, 16'sd0, 16'sd0, 16'sd0};
      send_beat(r);
      r = '{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 16'sd0};
      send_beat(r);
      r = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
      send_beat(r);
      r = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
      send_beat(r);
      r = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd1, 16'sd0};
      send_beat(r);
      r = '{16'sd5, 16'sd7, -16'sd9, 16'sd0, 16'sd0, 16'sd1};
      send_beat(r);
      r = '{16'sd300, -16'sd300, 16'sd1, 16'sd1, 16'sd0, 16'sd0};
      send_beat(r);
      for (int i = 0; i < 12; i++) begin
         r = {pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp()};
         send_beat(r);
      end
   endtask

   task automatic test_random_mix();
      lfdr_pkg::req_type r;
      for (int i = 0; i < 420; i++) begin
         if (i == 200) wait_drained();
         if ($urandom_range(0, 3) == 0)
            r = {pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp()};
         else
            r = random_unit_item();
         send_beat(r);
      end
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      for (int i = 0; i < 60; i++) send_beat(random_unit_item());
   endtask

   initial begin
      mismatches = 0;
      idle_enable = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix();
      test_back_to_back();
      wait_drained();
      repeat (80) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire

@@ filelist.f @@
design/lfdr_pkg.sv
design/lfdr_front.sv
design/lfdr_queue.sv
design/lfdr_sqrt.sv
design/lfdr_div.sv
design/lfdr_back.sv
design/local_frame_direction_rotate_core.sv
tb/local_frame_direction_rotate_core_test.sv
